FILE: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int VAL_W       = 32;
    localparam int PRI_W       = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [PRI_W-1:0] prio;
    } spq_entry_t;

    // Broadcast to every cell in the row
    typedef struct packed {
        logic       push;
        logic       pop;
        spq_entry_t item;
    } spq_ctrl_t;

endpackage

FILE: hw/rtl/spq_cell.sv
// One slot of the sorted queue: holds an entry, compares it with the broadcast
// key, and shifts toward either neighbor. Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  spq_ctrl_t  ctrl,
    input  logic       valid,
    input  logic       head,
    input  spq_entry_t left_entry,
    input  logic       left_before,
    input  spq_entry_t right_entry,
    output spq_entry_t entry,
    output logic       ahead
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // Entry stays ahead of the new key; equal key at the head also stays
    assign ahead = valid && ((entry_reg.prio < ctrl.item.prio) ||
                             (head && (entry_reg.prio == ctrl.item.prio)));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (!ahead)
            begin
                if (left_before)
                    entry_next = ctrl.item;
                else
                    entry_next = left_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue: a row of QUEUE_DEPTH cells kept in ascending priority.
// An accepted beat's result beat is registered and appears in the next cycle.
// Throughput: one push or pop per cycle while the input is not stalled; every cell compares and shifts at once.
// Input stalls only while a result is held and the output side stalls.
// Reset (rst_n, async low) empties the queue and drops any pending result.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [VAL_W-1:0] item_value,
    input  logic [PRI_W-1:0] item_priority,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       status,
    output logic [VAL_W-1:0] out_value,
    output logic [PRI_W-1:0] out_priority,
    output logic [OCC_W-1:0] occupancy
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    spq_status_t      status_reg, status_next;
    spq_entry_t       result_reg, result_next;
    logic [CNT_W-1:0] occ_reg, occ_next;

    spq_ctrl_t                ctrl;
    spq_entry_t               cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   cell_before;
    logic [QUEUE_DEPTH-1:0]   cell_valid;
    logic                     in_fire;
    logic                     is_full;
    logic                     is_empty;
    logic [OCC_W+CNT_W-1:0]   occ_ext;

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    assign ctrl.push       = in_fire && (kind == OP_PUSH) && !is_full;
    assign ctrl.pop        = in_fire && (kind == OP_POP) && !is_empty;
    assign ctrl.item.value = item_value;
    assign ctrl.item.prio  = item_priority;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign cell_valid[i] = (count_reg > CNT_W'(i));
        if (i == 0)
        begin : g_head
            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (cell_valid[i]),
                .head        (1'b1),
                .left_entry  (ctrl.item),
                .left_before (1'b1),
                .right_entry (cell_entry[i+1]),
                .entry       (cell_entry[i]),
                .ahead       (cell_before[i])
            );
        end
        else if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (cell_valid[i]),
                .head        (1'b0),
                .left_entry  (cell_entry[i-1]),
                .left_before (cell_before[i-1]),
                .right_entry (cell_entry[i]),
                .entry       (cell_entry[i]),
                .ahead       (cell_before[i])
            );
        end
        else
        begin : g_mid
            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (cell_valid[i]),
                .head        (1'b0),
                .left_entry  (cell_entry[i-1]),
                .left_before (cell_before[i-1]),
                .right_entry (cell_entry[i+1]),
                .entry       (cell_entry[i]),
                .ahead       (cell_before[i])
            );
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        result_next    = result_reg;
        occ_next       = occ_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            result_next    = '0;
            if (kind == OP_PUSH)
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                begin
                    result_next = cell_entry[0];
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            occ_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
        occ_reg    <= occ_next;
    end

    // occupancy wraps to its field width for deep queues
    assign occ_ext      = {{OCC_W{1'b0}}, occ_reg};
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_value    = result_reg.value;
    assign out_priority = result_reg.prio;
    assign occupancy    = occ_ext[OCC_W-1:0];

endmodule

FILE: hw/rtl/spq_checker.sv
// Port-level checks for sorted_priority_queue, bound to the top level.
// Depends on spq_pkg.
module spq_checker
    import spq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [1:0]       status,
    input logic [VAL_W-1:0] out_value,
    input logic [PRI_W-1:0] out_priority,
    input logic [OCC_W-1:0] occupancy
);

    // full-drop beat reports a full queue
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> occupancy == OCC_FULL)
        else $error("full status with occupancy %0d", occupancy);

    // empty pop leaves nothing behind and reports no data
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |->
            (occupancy == '0) && (out_value == '0) && (out_priority == '0))
        else $error("empty status with stale data");

    // every accepted beat gives a result beat on the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted beat produced no result");

    // held result beat does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) &&
            $stable(out_value) && $stable(out_priority) && $stable(occupancy))
        else $error("stalled result beat changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
